@@ rtl/dmc_pkg.sv @@
// ----------------------------------------------------------------------------
// Direct-mapped cache lookup package
// Shared types and constants for the direct-mapped cache lookup block.
// ----------------------------------------------------------------------------
`default_nettype none

package dmc_pkg;

  // Fixed widths of the configuration register and of the result fields.
  localparam int unsigned LineCountW = 11;
  localparam int unsigned LineIndexW = 10;
  localparam int unsigned LineTagW   = 32;

  localparam logic [LineCountW-1:0] LineCountReset = 11'd1024;

  localparam int unsigned MaxLinesDefault = 1024;
  localparam int unsigned AddrBitsDefault = 32;

  typedef enum logic [2:0] {
    StClear,
    StIdle,
    StDiv,
    StRead,
    StLookup
  } state_e;

endpackage

`default_nettype wire

@@ rtl/direct_mapped_cache_lookup.sv @@
// ----------------------------------------------------------------------------
// Direct-mapped cache lookup
// Splits each word address into line index and tag by the configured line
// count, checks the line for a hit and refills it on a miss.
// ----------------------------------------------------------------------------
//
//   Channel  | Handshake                   | Payload
//   ---------+-----------------------------+-----------------------------------
//   in       | in_valid_i / in_ready_o     | address_i
//   out      | out_valid_o / out_ready_i   | hit_o, evicted_o, line_index_o,
//            |                             | line_tag_o
//   cfg      | cfg_we_i (no wait)          | cfg_wdata_i (line_count)
//
// Each item runs one restoring divider step per address bit, then the line
// read and the compare and refill; the result is registered out of the
// compare stage, and no new item is taken until that result is registered.
// After reset the block sweeps the line store, one line per cycle, over
// every line before in_ready_o rises; configuration writes are taken.
// A stalled output holds the item in the compare stage until it is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module direct_mapped_cache_lookup import dmc_pkg::*; #(
  parameter int unsigned MAX_LINES = MaxLinesDefault,
  parameter int unsigned ADDR_BITS = AddrBitsDefault
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [LineCountW-1:0] cfg_wdata_i,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire logic [ADDR_BITS-1:0]  address_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output logic                       hit_o,
  output logic                       evicted_o,
  output logic [LineIndexW-1:0]      line_index_o,
  output logic [LineTagW-1:0]        line_tag_o
);

  localparam int unsigned IdxW   = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;
  localparam int unsigned MaxW   = $clog2(MAX_LINES + 1);
  localparam int unsigned DivW   = (MaxW > LineCountW) ? MaxW : LineCountW;
  localparam int unsigned CntW   = $clog2(ADDR_BITS);
  localparam int unsigned EntryW = ADDR_BITS + 1;

  localparam logic [IdxW-1:0] LastIdx   = IdxW'(MAX_LINES - 1);
  localparam logic [DivW-1:0] MaxDiv    = DivW'(MAX_LINES);
  localparam logic [CntW-1:0] LastStep  = CntW'(ADDR_BITS - 1);

  state_e state_q, state_d;

  logic [LineCountW-1:0] lc_q;
  logic [DivW-1:0]       div_q, div_d;
  logic [DivW-1:0]       rem_q, rem_d;
  logic [ADDR_BITS-1:0]  quo_q, quo_d;
  logic [CntW-1:0]       cnt_q, cnt_d;
  logic [IdxW-1:0]       clr_q, clr_d;

  logic                  out_valid_q, out_valid_d;
  logic                  hit_q, hit_d;
  logic                  evicted_q, evicted_d;
  logic [LineIndexW-1:0] index_q, index_d;
  logic [LineTagW-1:0]   tag_q, tag_d;

  // Line store: valid bit on top of the stored tag.
  logic [EntryW-1:0] mem_q [MAX_LINES];
  logic [EntryW-1:0] rd_q;
  logic              mem_we;
  logic [IdxW-1:0]   mem_waddr;
  logic [EntryW-1:0] mem_wdata;
  logic [IdxW-1:0]   line_idx;

  logic                  accept;
  logic                  out_free;
  logic [DivW-1:0]       lc_ext;
  logic [DivW-1:0]       eff_lines;
  logic [DivW:0]         trial;
  logic [DivW:0]         diff;
  logic                  ge;
  logic                  line_valid;
  logic                  line_hit;
  logic [IdxW+LineIndexW-1:0] idx_ext;
  logic [ADDR_BITS+LineTagW-1:0] tag_ext;

  assign accept   = in_valid_i && in_ready_o;
  assign out_free = !out_valid_q || out_ready_i;
  assign line_idx = rem_q[IdxW-1:0];

  // Effective line count: zero acts as one, large counts saturate.
  assign lc_ext = DivW'(lc_q);
  always_comb begin
    if (lc_ext == '0) begin
      eff_lines = DivW'(1);
    end else if (lc_ext > MaxDiv) begin
      eff_lines = MaxDiv;
    end else begin
      eff_lines = lc_ext;
    end
  end

  // One restoring division step: shift in the next address bit and subtract.
  assign trial = {rem_q, quo_q[ADDR_BITS-1]};
  assign diff  = trial - {1'b0, div_q};
  assign ge    = (trial >= {1'b0, div_q});

  assign line_valid = rd_q[EntryW-1];
  assign line_hit   = line_valid && (rd_q[ADDR_BITS-1:0] == quo_q);

  assign idx_ext = {{LineIndexW{1'b0}}, line_idx};
  assign tag_ext = {{LineTagW{1'b0}}, quo_q};

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      StClear: begin
        if (clr_q == LastIdx) begin
          state_d = StIdle;
        end
      end
      StIdle: begin
        if (accept) begin
          state_d = StDiv;
        end
      end
      StDiv: begin
        if (cnt_q == '0) begin
          state_d = StRead;
        end
      end
      StRead: begin
        state_d = StLookup;
      end
      StLookup: begin
        if (out_free) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // Datapath and output controls.
  always_comb begin
    in_ready_o  = 1'b0;
    div_d       = div_q;
    rem_d       = rem_q;
    quo_d       = quo_q;
    cnt_d       = cnt_q;
    clr_d       = clr_q;
    mem_we      = 1'b0;
    mem_waddr   = line_idx;
    mem_wdata   = {1'b1, quo_q};
    out_valid_d = out_valid_q && !out_ready_i;
    hit_d       = hit_q;
    evicted_d   = evicted_q;
    index_d     = index_q;
    tag_d       = tag_q;
    case (state_q)
      StClear: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = '0;
        clr_d     = clr_q + IdxW'(1);
      end
      StIdle: begin
        in_ready_o = 1'b1;
        if (accept) begin
          div_d = eff_lines;
          rem_d = '0;
          quo_d = address_i;
          cnt_d = LastStep;
        end
      end
      StDiv: begin
        rem_d = ge ? diff[DivW-1:0] : trial[DivW-1:0];
        quo_d = {quo_q[ADDR_BITS-2:0], ge};
        cnt_d = cnt_q - CntW'(1);
      end
      StRead: begin
        // The line read is issued from the remainder register this cycle.
      end
      StLookup: begin
        if (out_free) begin
          mem_we      = !line_hit;
          out_valid_d = 1'b1;
          hit_d       = line_hit;
          evicted_d   = !line_hit && line_valid;
          index_d     = idx_ext[LineIndexW-1:0];
          tag_d       = tag_ext[LineTagW-1:0];
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StClear;
      lc_q        <= LineCountReset;
      clr_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        lc_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    div_q     <= div_d;
    rem_q     <= rem_d;
    quo_q     <= quo_d;
    hit_q     <= hit_d;
    evicted_q <= evicted_d;
    index_q   <= index_d;
    tag_q     <= tag_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    rd_q <= mem_q[line_idx];
  end

  assign out_valid_o  = out_valid_q;
  assign hit_o        = hit_q;
  assign evicted_o    = evicted_q;
  assign line_index_o = index_q;
  assign line_tag_o   = tag_q;

  // A new result only appears out of the compare stage.
  a_result_from_lookup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == StLookup))
    else $error("result appeared outside the compare stage");

  // The divider must never run with a zero divisor.
  a_divisor_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StDiv) |-> (div_q != '0))
    else $error("divider running with zero divisor");

  // After the last step the remainder is below the divisor.
  a_rem_below_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StRead) |-> (rem_q < div_q))
    else $error("remainder not below divisor");

  // An eviction only ever comes with a miss.
  a_evict_on_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(hit_o && evicted_o))
    else $error("eviction flagged on a hit");

endmodule

`default_nettype wire
